// ===== sv/fmce_pkg.sv =====
// ----------------------------------------------------------------------------
// fmce_pkg: shared types and constants
// Request and result layouts, opcodes, modes, error codes, sequencer states
// and the sample store's entry and write request.
// ----------------------------------------------------------------------------
package fmce_pkg;

  // Opcodes of a request
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_ABORT  = 3'd3,
    OP_SUBMIT = 3'd4,
    OP_UPDATE = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_QUERY  = 3'd7
  } op_t;

  // Calibration mode
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_CAPTURE = 2'd1,
    MODE_WAIT    = 2'd2
  } mode_t;

  // Error codes
  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_UNAVAIL     = 4'd1,
    ERR_DISABLED    = 4'd2,
    ERR_REJECTED    = 4'd3,
    ERR_NOT_CAPTURE = 4'd4,
    ERR_BAD_SAMPLE  = 4'd5,
    ERR_BAD_INDEX   = 4'd6,
    ERR_NO_SAMPLES  = 4'd7,
    ERR_RANGE       = 4'd8
  } err_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a request
    S_EXEC,   // decode and apply the request
    S_RD,     // issue a read of one stored sample
    S_ACC,    // accumulate the sample read
    S_MUL,    // scale the volume sum
    S_DGO,    // launch the divider
    S_DIV,    // wait for the quotient
    S_EMIT    // hand the result to the output register
  } state_t;

  localparam logic [15:0] MS_PER_MIN  = 16'd60000;
  localparam logic [23:0] K_MAX_VALID = 24'd10000000;
  localparam logic [23:0] K_SAT       = 24'hFFFFFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] now_ms;
    logic [31:0] pulse_count;
    logic [7:0]  zone_id;
    logic        zone_enabled;
    logic        start_granted;
    logic [31:0] actual_ml;
    logic [7:0]  sample_index;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  error_code;
    logic [1:0]  mode;
    logic        stop_zone_request;
    logic        rec_valid;
    logic [23:0] rec_k;
    logic [3:0]  rec_sample_count;
    logic        rec_multi_point;
    logic [7:0]  first_sample_zone;
    logic [3:0]  stored_samples;
  } out_t;

  // One stored sample
  typedef struct packed {
    logic [31:0] pulses;
    logic [31:0] volume;
    logic [7:0]  zone;
  } sample_t;

  // Write request into the sample store
  typedef struct packed {
    logic    we_entry;   // write the whole entry
    logic    we_volume;  // write the volume only
    sample_t data;
  } wr_t;

endpackage

// ===== sv/flow_meter_calibration_engine_unit.sv =====
// ----------------------------------------------------------------------------
// flow_meter_calibration_engine_unit: flow-meter calibration sequencer
// Capture control, sample window in memory and factor recompute.
// ----------------------------------------------------------------------------
// Each request gives one result. Tick, start, stop, abort, clear, a rejected
// request and a query with a valid factor go from decode (S_EXEC) through
// S_EMIT to the output register. Submit, update and a query that recomputes
// sweep the stored samples through the sample memory's single read port
// (a read state and an accumulate state per sample) and then, if any sample
// is usable, run the serial divider, one quotient bit per cycle over SUM_W+16
// bits. No new request is taken until the previous one leaves S_EMIT.
// A new request is taken while the previous result still waits at the output.
module flow_meter_calibration_engine_unit
  import fmce_pkg::*;
#(
  parameter int SAMPLE_SLOTS = 8,
  parameter int MAX_ZONE     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W  = $clog2(SAMPLE_SLOTS);
  localparam int CNT_W  = $clog2(SAMPLE_SLOTS + 1);
  localparam int SUM_W  = 32 + CNT_W;
  localparam int PROD_W = SUM_W + 16;

  state_t state, state_next;

  logic [31:0]      max_ms;
  in_t              req;
  mode_t            mode_reg;
  logic [7:0]       active_zone;
  logic [31:0]      start_time;
  logic [31:0]      start_pulses;
  logic             pend_exists;
  logic             pend_valid;
  logic [31:0]      pend_pulses;
  logic [7:0]       pend_zone;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] total;
  logic             rec_valid;
  logic [23:0]      rec_k;
  logic [CNT_W-1:0] rec_count;
  logic [7:0]       first_zone;
  err_t             err_r;
  logic             stop_r;
  logic [CNT_W-1:0] sweep_i;
  logic [CNT_W-1:0] n_used;
  logic [SUM_W-1:0] sum_ml;
  logic [SUM_W-1:0] sum_p;
  logic [PROD_W-1:0] prod;

  op_t              op;
  logic             timeout;
  logic             bad_start;
  logic             bad_submit;
  logic             bad_update;
  logic             full;
  logic [31:0]      cap_delta;
  logic             cap_order;
  logic             do_recompute;

  wr_t              wr;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  sample_t          rd_data;

  logic              div_start;
  logic              div_done;
  logic [PROD_W-1:0] div_q;

  // ring position of a window offset
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IDX_W+1)'(SAMPLE_SLOTS)) begin
      s = s - (IDX_W+1)'(SAMPLE_SLOTS);
    end
    return s[IDX_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // request decode
  always_comb begin
    op         = op_t'(req.opcode);
    timeout    = (mode_reg == MODE_CAPTURE) && (max_ms != '0) &&
                 ((req.now_ms - start_time) >= max_ms);
    bad_start  = (req.zone_id == 8'd0) || (req.zone_id > 8'(MAX_ZONE)) ||
                 (mode_reg != MODE_IDLE);
    bad_submit = (mode_reg != MODE_WAIT) || !pend_exists || !pend_valid ||
                 (req.actual_ml == '0);
    bad_update = ({1'b0, req.sample_index} >= 9'(total)) ||
                 (req.actual_ml == '0);
    full       = (total >= CNT_W'(SAMPLE_SLOTS));
    cap_order  = (req.pulse_count >= start_pulses);
    cap_delta  = cap_order ? (req.pulse_count - start_pulses) : '0;
    do_recompute = ((op == OP_SUBMIT) && !bad_submit) ||
                   ((op == OP_UPDATE) && !bad_update) ||
                   ((op == OP_QUERY) && !rec_valid);
  end

  // next state and memory / divider controls
  always_comb begin
    state_next = state;
    wr         = '0;
    wr_addr    = '0;
    rd_en      = 1'b0;
    rd_addr    = phys(head, sweep_i[IDX_W-1:0]);
    div_start  = 1'b0;
    wr.data.pulses = pend_pulses;
    wr.data.volume = req.actual_ml;
    wr.data.zone   = pend_zone;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (op == OP_SUBMIT && !bad_submit) begin
          wr.we_entry = 1'b1;
          wr_addr     = full ? head : phys(head, total[IDX_W-1:0]);
        end else if (op == OP_UPDATE && !bad_update) begin
          wr.we_volume = 1'b1;
          wr_addr      = phys(head, req.sample_index[IDX_W-1:0]);
        end
        state_next = do_recompute ? S_RD : S_EMIT;
      end
      S_RD: begin
        if (sweep_i == total) begin
          state_next = S_MUL;
        end else begin
          rd_en      = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC:  state_next = S_RD;
      S_MUL:  state_next = (n_used == '0) ? S_EMIT : S_DGO;
      S_DGO: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // request capture and configuration
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req <= in_data;
    if (rst) max_ms <= '0;
    else if (cfg_valid && cfg_ready) max_ms <= cfg_data;
  end

  // calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_IDLE;
      active_zone  <= '0;
      start_time   <= '0;
      start_pulses <= '0;
      pend_exists  <= 1'b0;
      pend_valid   <= 1'b0;
      pend_pulses  <= '0;
      pend_zone    <= '0;
      head         <= '0;
      total        <= '0;
      rec_valid    <= 1'b0;
      rec_k        <= '0;
      rec_count    <= '0;
      err_r        <= ERR_NONE;
      stop_r       <= 1'b0;
    end else if (state == S_EXEC) begin
      err_r  <= ERR_NONE;
      stop_r <= 1'b0;
      unique case (op)
        OP_TICK, OP_STOP: begin
          if (op == OP_STOP && mode_reg != MODE_CAPTURE) begin
            err_r <= ERR_NOT_CAPTURE;
          end else if (op == OP_STOP || timeout) begin
            // finish the capture
            stop_r      <= 1'b1;
            pend_exists <= 1'b1;
            pend_pulses <= cap_delta;
            pend_valid  <= cap_order && (req.now_ms > start_time) &&
                           (cap_delta != '0);
            pend_zone   <= active_zone;
            mode_reg    <= MODE_WAIT;
          end
        end
        OP_START: begin
          if (bad_start) begin
            err_r <= ERR_UNAVAIL;
          end else if (!req.zone_enabled) begin
            err_r <= ERR_DISABLED;
          end else begin
            pend_exists <= 1'b0;
            pend_valid  <= 1'b0;
            pend_pulses <= '0;
            pend_zone   <= '0;
            if (!req.start_granted) begin
              err_r        <= ERR_REJECTED;
              mode_reg     <= MODE_IDLE;
              active_zone  <= '0;
              start_time   <= '0;
              start_pulses <= '0;
            end else begin
              mode_reg     <= MODE_CAPTURE;
              active_zone  <= req.zone_id;
              start_time   <= req.now_ms;
              start_pulses <= req.pulse_count;
            end
          end
        end
        OP_ABORT: begin
          stop_r       <= (active_zone != '0);
          mode_reg     <= MODE_IDLE;
          active_zone  <= '0;
          start_time   <= '0;
          start_pulses <= '0;
        end
        OP_SUBMIT: begin
          if (bad_submit) begin
            err_r <= ERR_BAD_SAMPLE;
          end else begin
            // oldest sample drops out when the window is full
            if (full) begin
              head <= phys(head, IDX_W'(1));
            end else begin
              total <= total + 1'b1;
            end
            pend_exists  <= 1'b0;
            pend_valid   <= 1'b0;
            pend_pulses  <= '0;
            pend_zone    <= '0;
            mode_reg     <= MODE_IDLE;
            active_zone  <= '0;
            start_time   <= '0;
            start_pulses <= '0;
          end
        end
        OP_UPDATE: begin
          if (bad_update) err_r <= ERR_BAD_INDEX;
        end
        OP_CLEAR: begin
          mode_reg     <= MODE_IDLE;
          active_zone  <= '0;
          start_time   <= '0;
          start_pulses <= '0;
          pend_exists  <= 1'b0;
          pend_valid   <= 1'b0;
          pend_pulses  <= '0;
          pend_zone    <= '0;
          head         <= '0;
          total        <= '0;
          rec_valid    <= 1'b0;
          rec_k        <= '0;
          rec_count    <= '0;
        end
        OP_QUERY: ;
        default: ;
      endcase
    end else if (state == S_MUL && n_used == '0) begin
      // nothing usable stored
      rec_valid <= 1'b0;
      rec_k     <= '0;
      rec_count <= '0;
      err_r     <= ERR_NO_SAMPLES;
    end else if (state == S_DIV && div_done) begin
      rec_valid <= (div_q != '0) && (div_q <= PROD_W'(K_MAX_VALID));
      rec_k     <= (div_q > PROD_W'(K_SAT)) ? K_SAT : div_q[23:0];
      rec_count <= n_used;
      err_r     <= ((div_q != '0) && (div_q <= PROD_W'(K_MAX_VALID))) ?
                   ERR_NONE : ERR_RANGE;
    end
  end

  // sample sweep and scaling
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      sweep_i <= '0;
      n_used  <= '0;
      sum_ml  <= '0;
      sum_p   <= '0;
    end else if (state == S_ACC) begin
      sweep_i <= sweep_i + 1'b1;
      if (sweep_i == '0) first_zone <= rd_data.zone;
      if (rd_data.volume != '0 && rd_data.pulses != '0) begin
        n_used <= n_used + 1'b1;
        sum_ml <= sum_ml + SUM_W'(rd_data.volume);
        sum_p  <= sum_p + SUM_W'(rd_data.pulses);
      end
    end else if (state == S_MUL) begin
      prod <= PROD_W'(sum_ml) * PROD_W'(MS_PER_MIN);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      out_data.ok                <= (err_r == ERR_NONE);
      out_data.error_code        <= err_r;
      out_data.mode              <= mode_reg;
      out_data.stop_zone_request <= stop_r;
      out_data.rec_valid         <= rec_valid;
      out_data.rec_k             <= rec_k;
      out_data.rec_sample_count  <= 4'(rec_count);
      out_data.rec_multi_point   <= (rec_count > CNT_W'(1));
      out_data.first_sample_zone <= (total != '0) ? first_zone : 8'd0;
      out_data.stored_samples    <= 4'(total);
    end
  end

  fmce_sample_mem #(
    .DEPTH(SAMPLE_SLOTS)
  ) u_mem (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fmce_div #(
    .DVD_W(PROD_W),
    .DVS_W(SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (sum_p),
    .done     (div_done),
    .quotient (div_q)
  );

`ifndef NO_ASSERTIONS
  a_rec_count: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> rec_count != '0)
    else $error("valid factor with no samples");

  a_total: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(SAMPLE_SLOTS))
    else $error("sample count beyond window");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_EXEC)
    else $error("accepted request not decoded");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("quotient outside divide wait");
`endif

endmodule

// ===== sv/fmce_sample_mem.sv =====
// ----------------------------------------------------------------------------
// fmce_sample_mem: sample store
// Synchronous memory of calibration samples, one write and one registered
// read port. Volume is held apart so an update can rewrite it alone.
// ----------------------------------------------------------------------------
module fmce_sample_mem
  import fmce_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  wr_t                        wr,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output sample_t                    rd_data
);

  logic [31:0] mem_pulses [DEPTH];
  logic [7:0]  mem_zone   [DEPTH];
  logic [31:0] mem_volume [DEPTH];

  // pulses and zone written per entry, volume also alone; one registered read
  always_ff @(posedge clk) begin
    if (wr.we_entry) begin
      mem_pulses[wr_addr] <= wr.data.pulses;
      mem_zone[wr_addr]   <= wr.data.zone;
    end
    if (wr.we_entry || wr.we_volume) begin
      mem_volume[wr_addr] <= wr.data.volume;
    end
    if (rd_en) begin
      rd_data.pulses <= mem_pulses[rd_addr];
      rd_data.zone   <= mem_zone[rd_addr];
      rd_data.volume <= mem_volume[rd_addr];
    end
  end

endmodule

// ===== sv/fmce_div.sv =====
// ----------------------------------------------------------------------------
// fmce_div: serial divider
// Restoring division, one quotient bit per cycle, DVD_W quotient bits per request.
// ----------------------------------------------------------------------------
module fmce_div
  import fmce_pkg::*;
#(
  parameter int DVD_W = 53,
  parameter int DVS_W = 37
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [CW-1:0]    count;
  logic             busy;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] shreg;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;

  // trial subtract
  always_comb begin
    rem_sh = {rem, shreg[DVD_W-1]};
    diff   = rem_sh - {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DVD_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      if (!diff[DVS_W]) begin
        rem   <= diff[DVS_W-1:0];
        shreg <= {shreg[DVD_W-2:0], 1'b1};
      end else begin
        rem   <= rem_sh[DVS_W-1:0];
        shreg <= {shreg[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = shreg;

endmodule

// ===== tb/fmce_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fmce_checker: calibration sequencer scoreboard
// Watches the request, result and register channels, models the sequencer
// and compares every result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fmce_checker
  import fmce_pkg::*;
#(
  parameter int SLOTS = 8,
  parameter int ZONES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_results
);

  // model state
  logic [31:0] timeout_ms;
  mode_t       cur_mode;
  logic [7:0]  act_zone;
  logic [31:0] t_start;
  logic [31:0] p_start;
  logic        cap_exists;
  logic        cap_good;
  logic [31:0] cap_pulses;
  logic [7:0]  cap_zone;
  logic [31:0] win_pulses [SLOTS];
  logic [31:0] win_volume [SLOTS];
  logic [7:0]  win_zone [SLOTS];
  int          win_count;
  logic        k_good;
  logic [23:0] k_value;
  logic [3:0]  k_count;

  out_t predicted_results[$];

  initial begin
    fail_count = 0;
  end
  assign pending_results = predicted_results.size();

  function automatic void go_idle();
    cur_mode = MODE_IDLE;
    act_zone = '0;
    t_start  = '0;
    p_start  = '0;
  endfunction

  function automatic void drop_capture();
    cap_exists = 1'b0;
    cap_good   = 1'b0;
    cap_pulses = '0;
    cap_zone   = '0;
  endfunction

  function automatic void end_capture(logic [31:0] now, logic [31:0] pc);
    logic order_ok;
    order_ok   = pc >= p_start;
    cap_exists = 1'b1;
    cap_pulses = order_ok ? pc - p_start : 32'd0;
    cap_good   = order_ok && now > t_start && cap_pulses != 0;
    cap_zone   = act_zone;
    cur_mode   = MODE_WAIT;
  endfunction

  // sum the window and derive the factor
  function automatic err_t calc_factor();
    logic [63:0] sum_ml;
    logic [63:0] sum_p;
    logic [63:0] k;
    int n;
    sum_ml = '0;
    sum_p  = '0;
    n = 0;
    for (int i = 0; i < win_count; i++) begin
      if (win_volume[i] != 0 && win_pulses[i] != 0) begin
        sum_ml += win_volume[i];
        sum_p  += win_pulses[i];
        n++;
      end
    end
    if (n == 0) begin
      k_good = 1'b0;
      k_value = '0;
      k_count = '0;
      return ERR_NO_SAMPLES;
    end
    k = (sum_ml * 64'd60000) / sum_p;
    k_good  = k > 0 && k <= 64'd10000000;
    k_value = (k > 64'hFFFFFF) ? 24'hFFFFFF : k[23:0];
    k_count = n[3:0];
    return k_good ? ERR_NONE : ERR_RANGE;
  endfunction

  function automatic out_t predict_result(in_t rq);
    out_t r;
    logic ok;
    logic stop_req;
    err_t err;
    ok = 1'b1;
    stop_req = 1'b0;
    err = ERR_NONE;
    case (op_t'(rq.opcode))
      OP_TICK: begin
        if (cur_mode == MODE_CAPTURE && timeout_ms != 0 &&
            (rq.now_ms - t_start) >= timeout_ms) begin
          stop_req = 1'b1;
          end_capture(rq.now_ms, rq.pulse_count);
        end
      end
      OP_START: begin
        if (rq.zone_id == 0 || rq.zone_id > ZONES || cur_mode != MODE_IDLE) begin
          ok = 1'b0; err = ERR_UNAVAIL;
        end else if (!rq.zone_enabled) begin
          ok = 1'b0; err = ERR_DISABLED;
        end else begin
          drop_capture();
          if (!rq.start_granted) begin
            go_idle();
            ok = 1'b0; err = ERR_REJECTED;
          end else begin
            act_zone = rq.zone_id;
            t_start  = rq.now_ms;
            p_start  = rq.pulse_count;
            cur_mode = MODE_CAPTURE;
          end
        end
      end
      OP_STOP: begin
        if (cur_mode != MODE_CAPTURE) begin
          ok = 1'b0; err = ERR_NOT_CAPTURE;
        end else begin
          stop_req = 1'b1;
          end_capture(rq.now_ms, rq.pulse_count);
        end
      end
      OP_ABORT: begin
        stop_req = act_zone != 0;
        go_idle();
      end
      OP_SUBMIT: begin
        if (cur_mode != MODE_WAIT || !cap_exists || !cap_good || rq.actual_ml == 0) begin
          ok = 1'b0; err = ERR_BAD_SAMPLE;
        end else begin
          if (win_count >= SLOTS) begin
            for (int i = 1; i < SLOTS; i++) begin
              win_pulses[i-1] = win_pulses[i];
              win_volume[i-1] = win_volume[i];
              win_zone[i-1]   = win_zone[i];
            end
            win_count = SLOTS - 1;
          end
          win_pulses[win_count] = cap_pulses;
          win_volume[win_count] = rq.actual_ml;
          win_zone[win_count]   = cap_zone;
          win_count++;
          drop_capture();
          go_idle();
          err = calc_factor();
          ok = err == ERR_NONE;
        end
      end
      OP_UPDATE: begin
        if (rq.sample_index >= win_count || rq.actual_ml == 0) begin
          ok = 1'b0; err = ERR_BAD_INDEX;
        end else begin
          win_volume[rq.sample_index] = rq.actual_ml;
          err = calc_factor();
          ok = err == ERR_NONE;
        end
      end
      OP_CLEAR: begin
        go_idle();
        drop_capture();
        win_count = 0;
        k_good = 1'b0;
        k_value = '0;
        k_count = '0;
      end
      default: begin
        if (!k_good) begin
          err = calc_factor();
          ok = err == ERR_NONE;
        end
      end
    endcase
    r.ok                = ok;
    r.error_code        = err;
    r.mode              = cur_mode;
    r.stop_zone_request = stop_req;
    r.rec_valid         = k_good;
    r.rec_k             = k_value;
    r.rec_sample_count  = k_count;
    r.rec_multi_point   = k_count > 1;
    r.first_sample_zone = (win_count > 0) ? win_zone[0] : 8'd0;
    r.stored_samples    = win_count[3:0];
    return r;
  endfunction

  // compare one field, report on mismatch
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      timeout_ms = '0;
      go_idle();
      drop_capture();
      win_count = 0;
      k_good = 1'b0;
      k_value = '0;
      k_count = '0;
      predicted_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) timeout_ms = cfg_data;
      if (in_valid && in_ready) predicted_results.push_back(predict_result(in_data));
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("ok", want.ok, out_data.ok);
          check_field("error_code", want.error_code, out_data.error_code);
          check_field("mode", want.mode, out_data.mode);
          check_field("stop_zone_request", want.stop_zone_request,
                      out_data.stop_zone_request);
          check_field("rec_valid", want.rec_valid, out_data.rec_valid);
          check_field("rec_k", want.rec_k, out_data.rec_k);
          check_field("rec_sample_count", want.rec_sample_count, out_data.rec_sample_count);
          check_field("rec_multi_point", want.rec_multi_point, out_data.rec_multi_point);
          check_field("first_sample_zone", want.first_sample_zone,
                      out_data.first_sample_zone);
          check_field("stored_samples", want.stored_samples, out_data.stored_samples);
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: calibration sequencer top
// Drives directed then random request sequences with idle and stall phases,
// writes the timeout register between phases and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import fmce_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending_results;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  always #1 clk = ~clk;

  flow_meter_calibration_engine_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  fmce_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  // result side stalls
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // timeout guard
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // one request, with a random gap first; valid stays up into the next
  // request when there is no gap, and is dropped during the gap otherwise
  task automatic send_request(in_t rq);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_timeout(logic [31:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t make_request(op_t op, logic [31:0] now, logic [31:0] pc,
                                       logic [7:0] zone, logic [31:0] ml);
    in_t rq;
    rq = '0;
    rq.opcode = op;
    rq.now_ms = now;
    rq.pulse_count = pc;
    rq.zone_id = zone;
    rq.zone_enabled = 1'b1;
    rq.start_granted = 1'b1;
    rq.actual_ml = ml;
    rq.sample_index = 8'($urandom_range(9));
    return rq;
  endfunction

  function automatic logic [31:0] rnd_wide();
    case ($urandom_range(3))
      0: return $urandom_range(20);
      1: return 32'hFFFFFFFF - $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  // a well formed capture: start, maybe ticks, stop or timeout, submit
  task automatic capture_sequence();
    logic [31:0] t0;
    logic [31:0] p0;
    in_t rq;
    t0 = ($urandom_range(3) == 0) ? rnd_wide() : $urandom_range(1000000);
    p0 = ($urandom_range(3) == 0) ? rnd_wide() : $urandom_range(1000000);
    rq = make_request(OP_START, t0, p0, 8'($urandom_range(1, 16)), 0);
    if ($urandom_range(15) == 0) rq.start_granted = 1'b0;
    send_request(rq);
    repeat ($urandom_range(2)) begin
      send_request(make_request(OP_TICK, t0 + $urandom_range(20000),
                                p0 + $urandom_range(5000), 0, 0));
    end
    rq = make_request(($urandom_range(1) != 0) ? OP_STOP : OP_TICK,
                      t0 + $urandom_range(1, 60000), p0 + $urandom_range(20000), 0, 0);
    if ($urandom_range(9) == 0) rq.pulse_count = rnd_wide();
    send_request(rq);
    send_request(make_request(OP_SUBMIT, 0, 0, 0,
                              ($urandom_range(7) == 0) ? rnd_wide() : $urandom_range(50000)));
  endtask

  task automatic random_request();
    in_t rq;
    rq = in_t'({$urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(1) != 0) rq.zone_id = 8'($urandom_range(17));
    if ($urandom_range(1) != 0) rq.sample_index = 8'($urandom_range(9));
    send_request(rq);
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; ) begin
      if ($urandom_range(9) < 7) begin
        capture_sequence();
        n += 4;
      end else begin
        random_request();
        n++;
      end
    end
  endtask

  initial begin
    in_t rq;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: error paths and extremes
    write_timeout(32'd0);
    send_request(make_request(OP_QUERY, 0, 0, 0, 0));
    send_request(make_request(OP_STOP, 0, 0, 0, 0));
    send_request(make_request(OP_SUBMIT, 0, 0, 0, 5));
    send_request(make_request(OP_UPDATE, 0, 0, 0, 5));
    rq = make_request(OP_START, 0, 0, 8'd0, 0);
    send_request(rq);
    rq.zone_id = 8'd17;
    send_request(rq);
    rq.zone_id = 8'd255;
    send_request(rq);
    rq.zone_id = 8'd1;
    rq.zone_enabled = 1'b0;
    send_request(rq);
    rq.zone_enabled = 1'b1;
    rq.start_granted = 1'b0;
    send_request(rq);
    send_request(make_request(OP_START, 32'hFFFFFFF0, 32'hFFFFFFFF, 8'd16, 0));
    send_request(make_request(OP_START, 0, 0, 8'd3, 0));
    send_request(make_request(OP_TICK, 32'h10, 32'd0, 0, 0));
    send_request(make_request(OP_STOP, 32'hFFFFFFFF, 32'd5, 0, 0));
    send_request(make_request(OP_SUBMIT, 0, 0, 0, 32'd0));
    send_request(make_request(OP_ABORT, 0, 0, 0, 0));
    send_request(make_request(OP_START, 32'd100, 32'd0, 8'd2, 0));
    send_request(make_request(OP_STOP, 32'd200, 32'd1, 0, 0));
    send_request(make_request(OP_SUBMIT, 0, 0, 0, 32'hFFFFFFFF));
    rq = make_request(OP_UPDATE, 0, 0, 0, 32'd1);
    rq.sample_index = 8'd0;
    send_request(rq);
    send_request(make_request(OP_QUERY, 0, 0, 0, 0));
    send_request(make_request(OP_ABORT, 0, 0, 0, 0));
    send_request(make_request(OP_CLEAR, 0, 0, 0, 0));

    // timeout on a tick, then the largest timeout
    write_timeout(32'd1);
    send_request(make_request(OP_START, 32'd50, 32'd10, 8'd4, 0));
    send_request(make_request(OP_TICK, 32'd51, 32'd20, 0, 0));
    send_request(make_request(OP_SUBMIT, 0, 0, 0, 32'd100));
    write_timeout(32'hFFFFFFFF);
    run_phase(150, 0, 0);

    write_timeout(32'd5000);
    run_phase(200, 79, 0);
    write_timeout(32'd20000);
    run_phase(200, 0, 79);

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        run_phase(30, 0, 0);
        in_valid <= 1'b0;
      end
    join

    // sender pauses until all results are in
    drain_results();
    write_timeout(32'd0);
    run_phase(200, 18, 18);
    write_timeout(32'd30000);
    run_phase(170, 0, 0);

    drain_results();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/fmce_pkg.sv
sv/fmce_sample_mem.sv
sv/fmce_div.sv
sv/flow_meter_calibration_engine_unit.sv
tb/fmce_checker.sv
tb/testbench.sv
